[hdl/lsp_pkg.sv]
// Shared types and constants of the looped sample player.
// Used by every module in this folder; depends on nothing.
package lsp_pkg;

   localparam int ADDR_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int SMOOTH_W   = 32;

   // Smoother coefficients: 0.001 and 0.999 as 16-bit fractions summing to one.
   localparam logic [6:0]  COEF_NEW = 7'd66;
   localparam logic [15:0] COEF_OLD = 16'd65470;

   localparam int RAMP_LEN    = 256;
   localparam int FADE_W      = $clog2(RAMP_LEN + 1);
   localparam int SCALE_SHIFT = $clog2(RAMP_LEN) + 14;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_LOOP_START  = 2'd0,
      CSR_LOOP_END    = 2'd1,
      CSR_GAIN_TARGET = 2'd2,
      CSR_MONO_SOURCE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_MUL1,
      ST_MUL2
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } smooth_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

[hdl/looped_sample_player.sv]
// Looped sample player: frame store, gain smoother and fade, valid/ready channels.
// A tick passes ACCESS, MUL1 and MUL2 before its beat on rsp; a load only ACCESS.
// Requests are taken only in IDLE; a full result register stalls MUL2.
// Reset clears control state, loaded flag, smoother, fade, position; CSRs to defaults.
// The frame store is not cleared; unwritten frames read as whatever they hold.
// Depends on lsp_pkg, lsp_frame_store, lsp_gain_smoother, lsp_sample_scaler.
module looped_sample_player #(
   parameter int FRAMES      = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [lsp_pkg::ADDR_W-1:0]         req_address,
   input  logic signed [SAMPLE_BITS-1:0]      req_load_left,
   input  logic signed [SAMPLE_BITS-1:0]      req_load_right,
   input  logic                               req_enable,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(FRAMES);
   // Frame index: address or position modulo FRAMES, via a reciprocal and one fix-up.
   localparam longint unsigned RECIP_L = (64'd1 << 32) / FRAMES;
   localparam logic [31:0] RECIP = 32'(RECIP_L);
   localparam logic [15:0] FRAMES_LO = 16'(FRAMES);
   localparam logic [16:0] FRAMES_CMP = (FRAMES > 65535) ? 17'h1FFFF : 17'(FRAMES);
   localparam int FW = lsp_pkg::FADE_W;
   localparam logic [FW-1:0] RAMP_FULL = FW'(lsp_pkg::RAMP_LEN);

   // Configuration registers.
   logic [15:0] loop_start_ff, loop_end_ff, gain_target_ff;
   logic mono_ff;

   // Control and state.
   lsp_pkg::state_type state_ff, state_in;
   logic loaded_ff;
   logic [15:0] pos_ff, pos_in;
   logic [FW-1:0] fade_ff, fade_in;
   logic [FW-1:0] f_ff, f_in;
   logic silence_ff;
   logic rsp_valid_ff;

   // Item payload.
   logic kind_ff, enable_ff;
   logic [15:0] src_ff;
   logic [15:0] q_ff;
   logic [SAMPLE_BITS-1:0] ld_left_ff, ld_right_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;

   logic accept, active, out_load;
   logic [15:0] src_in;
   logic [47:0] q_prod;
   logic [31:0] qf_prod;
   logic [15:0] rem;
   logic [15:0] rem_fix;
   logic [AW-1:0] frame_idx;
   logic [16:0] p;
   logic [17:0] p_ramp;

   lsp_pkg::smooth_ctl_type smooth_ctl;
   lsp_pkg::store_ctl_type store_ctl;
   logic [lsp_pkg::GAIN_W-1:0] gain;
   logic [2*SAMPLE_BITS-1:0] rdata;
   logic signed [SAMPLE_BITS-1:0] smp_left, smp_right, res_left, res_right;
   logic stage_en;

   assign accept = req_valid && req_ready;
   assign active = (kind_ff == lsp_pkg::KIND_TICK) && enable_ff && loaded_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_start_ff  <= 16'd0;
         loop_end_ff    <= 16'hFFFF;
         gain_target_ff <= 16'd16384;
         mono_ff        <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (lsp_pkg::csr_index_type'(csr_index))
            lsp_pkg::CSR_LOOP_START:  loop_start_ff  <= csr_wdata;
            lsp_pkg::CSR_LOOP_END:    loop_end_ff    <= csr_wdata;
            lsp_pkg::CSR_GAIN_TARGET: gain_target_ff <= csr_wdata;
            lsp_pkg::CSR_MONO_SOURCE: mono_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsp_pkg::ST_IDLE:   if (accept) state_in = lsp_pkg::ST_ACCESS;
         lsp_pkg::ST_ACCESS: state_in = (kind_ff == lsp_pkg::KIND_TICK) ?
                                        lsp_pkg::ST_MUL1 : lsp_pkg::ST_IDLE;
         lsp_pkg::ST_MUL1:   state_in = lsp_pkg::ST_MUL2;
         lsp_pkg::ST_MUL2:   if (!rsp_valid_ff || rsp_ready) state_in = lsp_pkg::ST_IDLE;
         default:            state_in = lsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      smooth_ctl = '0;
      store_ctl = '0;
      stage_en = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         lsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            smooth_ctl.capture = accept;
         end
         lsp_pkg::ST_ACCESS: begin
            store_ctl.wr_en = (kind_ff == lsp_pkg::KIND_LOAD);
            store_ctl.rd_en = active;
            smooth_ctl.commit = active;
         end
         lsp_pkg::ST_MUL1: stage_en = 1'b1;
         lsp_pkg::ST_MUL2: out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- frame index ----------------
   assign src_in = (req_kind == lsp_pkg::KIND_TICK) ? pos_ff : req_address;
   assign q_prod = src_in * RECIP;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         enable_ff   <= req_enable;
         src_ff      <= src_in;
         q_ff        <= q_prod[47:32];
         ld_left_ff  <= req_load_left;
         ld_right_ff <= req_load_right;
      end
   end

   always_comb begin
      qf_prod = q_ff * FRAMES_LO;
      rem = src_ff - qf_prod[15:0];
      rem_fix = ({1'b0, rem} >= FRAMES_CMP) ? (rem - FRAMES_LO) : rem;
      frame_idx = AW'(rem_fix);
   end

   // ---------------- position and fade ----------------
   always_comb begin
      p = {1'b0, pos_ff} + 17'd1;
      p_ramp = {1'b0, p} + 18'(lsp_pkg::RAMP_LEN);
      pos_in = p[15:0];
      fade_in = fade_ff;
      f_in = RAMP_FULL;
      if (p > {1'b0, loop_end_ff}) begin
         pos_in = loop_start_ff;
      end else if (p <= {1'b0, loop_start_ff}) begin
         pos_in = loop_end_ff;
      end else if (p_ramp < {2'b0, loop_start_ff} + 18'(2 * lsp_pkg::RAMP_LEN)) begin
         // Inside the fade-in zone just past the loop start.
         fade_in = (fade_ff < RAMP_FULL) ? fade_ff + 1'b1 : fade_ff;
         f_in = fade_in;
      end else if (p_ramp > {2'b0, loop_end_ff}) begin
         // Inside the fade-out zone before the loop end.
         fade_in = (fade_ff != '0) ? fade_ff - 1'b1 : fade_ff;
         f_in = fade_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         pos_ff    <= '0;
         fade_ff   <= '0;
      end else if (state_ff == lsp_pkg::ST_ACCESS) begin
         if (kind_ff == lsp_pkg::KIND_LOAD) begin
            loaded_ff <= 1'b1;
         end else if (active) begin
            pos_ff  <= pos_in;
            fade_ff <= fade_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lsp_pkg::ST_ACCESS) begin
         f_ff       <= f_in;
         silence_ff <= !active;
      end
   end

   // ---------------- datapath units ----------------
   lsp_frame_store #(
      .FRAMES      (FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock (clock),
      .ctl   (store_ctl),
      .addr  (frame_idx),
      .wdata ({ld_left_ff, ld_right_ff}),
      .rdata (rdata)
   );

   lsp_gain_smoother u_smoother (
      .clock       (clock),
      .reset       (reset),
      .ctl         (smooth_ctl),
      .gain_target (gain_target_ff),
      .gain        (gain)
   );

   assign smp_left  = rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign smp_right = mono_ff ? rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : rdata[SAMPLE_BITS-1:0];

   lsp_sample_scaler #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_left (
      .clock    (clock),
      .stage_en (stage_en),
      .sample   (smp_left),
      .gain     (gain),
      .fade     (f_ff),
      .result   (res_left)
   );

   lsp_sample_scaler #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_right (
      .clock    (clock),
      .stage_en (stage_en),
      .sample   (smp_right),
      .gain     (gain),
      .fade     (f_ff),
      .result   (res_right)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_left_ff  <= silence_ff ? '0 : res_left;
         out_right_ff <= silence_ff ? '0 : res_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // ---------------- assertions ----------------
   a_beat_from_mul2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lsp_pkg::ST_MUL2))
      else $error("result beat raised outside the final multiply cycle");

   a_silent_tick_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsp_pkg::ST_ACCESS && kind_ff == lsp_pkg::KIND_TICK && !active)
      |=> ($stable(pos_ff) && $stable(fade_ff)))
      else $error("silent tick changed position or fade");

   a_stall_holds_mul2: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsp_pkg::ST_MUL2 && rsp_valid_ff && !rsp_ready)
      |=> state_ff == lsp_pkg::ST_MUL2)
      else $error("sequencer left the final stage while the result register was full");

   a_fade_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsp_pkg::ST_MUL1) |-> (f_ff <= RAMP_FULL && fade_ff <= RAMP_FULL))
      else $error("fade ramp beyond its full length");

endmodule

[hdl/lsp_frame_store.sv]
// Frame store of the looped sample player: one synchronous single-port memory.
// Each word holds a left and a right sample; read data is registered.
// Depends on lsp_pkg.
module lsp_frame_store #(
   parameter int FRAMES      = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  lsp_pkg::store_ctl_type         ctl,
   input  logic [$clog2(FRAMES)-1:0]      addr,
   input  logic [2*SAMPLE_BITS-1:0]       wdata,
   output logic [2*SAMPLE_BITS-1:0]       rdata
);

   logic [2*SAMPLE_BITS-1:0] mem [FRAMES];
   logic [2*SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/lsp_gain_smoother.sv]
// One-pole gain smoother: Q2.30 state moved toward the Q2.14 target per tick.
// The old-state product is registered before the commit cycle. Depends on lsp_pkg.
module lsp_gain_smoother (
   input  logic                          clock,
   input  logic                          reset,
   input  lsp_pkg::smooth_ctl_type       ctl,
   input  logic [lsp_pkg::GAIN_W-1:0]    gain_target,
   output logic [lsp_pkg::GAIN_W-1:0]    gain
);

   logic [lsp_pkg::SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [47:0] prod_ff;
   logic [lsp_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [22:0] target_term;
   logic [48:0] sum;
   logic [32:0] next_raw;
   logic [16:0] gain_raw;

   always_comb begin
      target_term = lsp_pkg::COEF_NEW * gain_target;
      sum = {10'b0, target_term, 16'b0} + {1'b0, prod_ff} + 49'd32768;
      next_raw = sum[48:16];
      smooth_in = next_raw[32] ? {lsp_pkg::SMOOTH_W{1'b1}} : next_raw[31:0];
      gain_raw = 17'({1'b0, smooth_in[31:16]}) + 17'(smooth_in[15]);
      gain_in = gain_raw[16] ? {lsp_pkg::GAIN_W{1'b1}} : gain_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         prod_ff <= lsp_pkg::COEF_OLD * smooth_ff;
      end
      if (ctl.commit) begin
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
      end else if (ctl.commit) begin
         smooth_ff <= smooth_in;
      end
   end

   assign gain = gain_ff;

endmodule

[hdl/lsp_sample_scaler.sv]
// Scales one sample by gain and fade in two multiply stages, then rounds
// half away from zero and saturates. Depends on lsp_pkg.
module lsp_sample_scaler #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              stage_en,
   input  logic signed [SAMPLE_BITS-1:0]     sample,
   input  logic [lsp_pkg::GAIN_W-1:0]        gain,
   input  logic [lsp_pkg::FADE_W-1:0]        fade,
   output logic signed [SAMPLE_BITS-1:0]     result
);

   localparam int P1W = SAMPLE_BITS + lsp_pkg::GAIN_W;
   localparam int P2W = P1W + lsp_pkg::FADE_W;
   localparam int QW  = P2W + 1 - lsp_pkg::SCALE_SHIFT;
   localparam logic [QW-1:0] POS_MAX = QW'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [QW-1:0] NEG_MAX = QW'(1 << (SAMPLE_BITS - 1));
   localparam logic [P2W:0]  ROUND   = (P2W + 1)'(1) << (lsp_pkg::SCALE_SHIFT - 1);

   logic [SAMPLE_BITS-1:0] mag;
   logic [P1W-1:0] p1_ff;
   logic neg_ff;
   logic [P2W-1:0] p2;
   logic [P2W:0] rounded;
   logic [QW-1:0] q;
   logic [QW-1:0] q_neg;

   assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         p1_ff  <= mag * gain;
         neg_ff <= sample[SAMPLE_BITS-1];
      end
   end

   always_comb begin
      p2 = p1_ff * fade;
      rounded = {1'b0, p2} + ROUND;
      q = rounded[P2W:lsp_pkg::SCALE_SHIFT];
      q_neg = ~q + 1'b1;
      if (neg_ff) begin
         result = (q > NEG_MAX) ? NEG_MAX[SAMPLE_BITS-1:0] : q_neg[SAMPLE_BITS-1:0];
      end else begin
         result = (q > POS_MAX) ? POS_MAX[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
      end
   end

endmodule
